FILE: src/cdeq_pkg.sv
`default_nettype none
package cdeq_pkg;

    // Ring geometry
    localparam int DEPTH       = 64;
    localparam int ENTRY_WIDTH = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // Beat layout
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = ((OP_W + ENTRY_WIDTH + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + 2 * ENTRY_WIDTH + CNT_W + 2;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_STATUS     = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL_ERR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_ERR  = 2'd2;

    // Slot memory request from the pointer unit
    typedef struct packed {
        logic                   wr_en;
        logic [IDX_W-1:0]       wr_addr;
        logic [ENTRY_WIDTH-1:0] wr_data;
        logic                   rd_en;
        logic [IDX_W-1:0]       rd_front_addr;
        logic [IDX_W-1:0]       rd_back_addr;
    } mem_req_t;

    // Per-item result control carried to the read stage
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    occupancy;
        logic                full;
        logic                empty;
        logic                byp_front;
        logic                byp_back;
    } step_res_t;

endpackage
`default_nettype wire

FILE: src/cdeq_ram.sv
`default_nettype none
module cdeq_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [DATA_W-1:0] rd_data_a,
    output logic      [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
`default_nettype wire

FILE: src/cdeq_ctrl.sv
`default_nettype none
module cdeq_ctrl (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [cdeq_pkg::CNT_W-1:0]             cfg_wdata,
    input  wire logic                                   accept,
    input  wire logic [cdeq_pkg::OP_W-1:0]              op,
    input  wire logic [cdeq_pkg::ENTRY_WIDTH-1:0]       value,
    output cdeq_pkg::mem_req_t                          mem_req,
    output cdeq_pkg::step_res_t                         res
);

    localparam logic [cdeq_pkg::IDX_W-1:0] IDX_MAX   = cdeq_pkg::IDX_W'(cdeq_pkg::DEPTH - 1);
    localparam logic [cdeq_pkg::CNT_W-1:0] CNT_DEPTH = cdeq_pkg::CNT_W'(cdeq_pkg::DEPTH);
    localparam logic [cdeq_pkg::CNT_W-1:0] CNT_ONE   = cdeq_pkg::CNT_W'(1);

    logic [cdeq_pkg::CNT_W-1:0] capacity_reg;
    logic [cdeq_pkg::IDX_W-1:0] front_reg, front_next;
    logic [cdeq_pkg::IDX_W-1:0] back_reg, back_next;
    logic [cdeq_pkg::CNT_W-1:0] count_reg, count_next;

    logic [cdeq_pkg::CNT_W-1:0] cap;
    logic [cdeq_pkg::CNT_W-1:0] cap_dec;
    logic [cdeq_pkg::IDX_W-1:0] cap_m1;
    logic                       full, empty;
    logic                       wr_en;
    logic [cdeq_pkg::IDX_W-1:0] wr_addr;
    logic [cdeq_pkg::STATUS_W-1:0] status;

    function automatic logic [cdeq_pkg::IDX_W-1:0] step_up(
        input logic [cdeq_pkg::IDX_W-1:0] idx,
        input logic [cdeq_pkg::IDX_W-1:0] last
    );
        logic [cdeq_pkg::IDX_W-1:0] r;
        if (idx == last || idx == IDX_MAX)
            r = '0;
        else
            r = idx + cdeq_pkg::IDX_W'(1);
        return r;
    endfunction

    function automatic logic [cdeq_pkg::IDX_W-1:0] step_down(
        input logic [cdeq_pkg::IDX_W-1:0] idx,
        input logic [cdeq_pkg::IDX_W-1:0] last
    );
        logic [cdeq_pkg::IDX_W-1:0] r;
        if (idx == '0)
            r = last;
        else
            r = idx - cdeq_pkg::IDX_W'(1);
        return r;
    endfunction

    // Effective capacity: zero acts as one, above depth clamps to depth
    always_comb
    begin
        if (capacity_reg == '0)
            cap = CNT_ONE;
        else if (capacity_reg > CNT_DEPTH)
            cap = CNT_DEPTH;
        else
            cap = capacity_reg;
        cap_dec = cap - CNT_ONE;
        cap_m1  = cap_dec[cdeq_pkg::IDX_W-1:0];
    end

    assign full  = (count_reg >= cap);
    assign empty = (count_reg == '0);

    // Pointer and count update
    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        status     = cdeq_pkg::ST_DONE;
        unique case (op) inside
            cdeq_pkg::OP_PUSH_BACK, cdeq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = cdeq_pkg::ST_FULL_ERR;
                end
                else
                begin
                    if (empty)
                    begin
                        front_next = '0;
                        back_next  = '0;
                    end
                    else if (op == cdeq_pkg::OP_PUSH_BACK)
                    begin
                        back_next = step_up(back_reg, cap_m1);
                    end
                    else
                    begin
                        front_next = step_down(front_reg, cap_m1);
                    end
                    wr_en      = 1'b1;
                    wr_addr    = (op == cdeq_pkg::OP_PUSH_BACK) ? back_next : front_next;
                    count_next = count_reg + CNT_ONE;
                end
            end
            cdeq_pkg::OP_POP_BACK, cdeq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status = cdeq_pkg::ST_EMPTY_ERR;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE)
                    begin
                        front_next = '0;
                        back_next  = '0;
                    end
                    else if (op == cdeq_pkg::OP_POP_BACK)
                    begin
                        back_next = step_down(back_reg, cap_m1);
                    end
                    else
                    begin
                        front_next = step_up(front_reg, cap_m1);
                    end
                end
            end
            default:
            begin
                status = cdeq_pkg::ST_DONE;
            end
        endcase
    end

    // Memory request and result control for this item
    always_comb
    begin
        mem_req.wr_en         = accept && wr_en;
        mem_req.wr_addr       = wr_addr;
        mem_req.wr_data       = value;
        mem_req.rd_en         = accept;
        mem_req.rd_front_addr = front_next;
        mem_req.rd_back_addr  = back_next;

        res.status    = status;
        res.occupancy = count_next;
        res.full      = (count_next >= cap);
        res.empty     = (count_next == '0);
        res.byp_front = wr_en && (wr_addr == front_next);
        res.byp_back  = wr_en && (wr_addr == back_next);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CNT_DEPTH;
            front_reg    <= '0;
            back_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (accept)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                count_reg <= count_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/circular_double_ended_queue.sv
`default_nettype none
// Ring-buffer double-ended queue. Each input beat carries an operation (push back,
// push front, pop back, pop front, status) and an entry value; each one yields
// exactly one output beat with a status code, the front and back entries (0 when
// empty), the occupancy and the full and empty flags. A push into a full queue or
// a pop from an empty one changes nothing and reports an error. Entries live in a
// 64-slot memory with two registered read ports; pointers and count update in the
// accept cycle, and the result is registered in the read stage, then in the output
// register. One beat is taken per cycle when the output is drained, one item per clock.
// cfg_wdata sets the number of ring slots in use (0 acts as 1, above 64 as 64); it
// resets to 64 and should be written only while the queue is idle.
module circular_double_ended_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cdeq_pkg::CNT_W-1:0]    cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [2:0] operation, [18:3] entry_value, rest zero
    input  wire logic [cdeq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] status_code, [17:2] front_value, [33:18] back_value,
    // [40:34] occupancy, [41] full_flag, [42] empty_flag, rest zero
    output logic      [cdeq_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int EW = cdeq_pkg::ENTRY_WIDTH;

    cdeq_pkg::mem_req_t  mem_req;
    cdeq_pkg::step_res_t res;

    logic          accept;
    logic          s1_move;
    logic          s1_valid_reg;
    cdeq_pkg::step_res_t s1_res_reg;
    logic [EW-1:0] s1_wdata_reg;
    logic [EW-1:0] rd_front, rd_back;
    logic [EW-1:0] front_val, back_val;
    logic [cdeq_pkg::M_FIELDS_W-1:0] out_fields;
    logic          m_tvalid_reg;
    logic [cdeq_pkg::M_DATA_W-1:0] m_tdata_reg;

    // Handshake: read stage advances when the output register is free or being read
    assign s1_move  = !m_tvalid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    cdeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .op        (s_tdata[cdeq_pkg::OP_W-1:0]),
        .value     (s_tdata[cdeq_pkg::OP_W +: EW]),
        .mem_req   (mem_req),
        .res       (res)
    );

    cdeq_ram #(
        .ADDR_W (cdeq_pkg::IDX_W),
        .DATA_W (EW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (mem_req.wr_en),
        .wr_addr   (mem_req.wr_addr),
        .wr_data   (mem_req.wr_data),
        .rd_en     (mem_req.rd_en),
        .rd_addr_a (mem_req.rd_front_addr),
        .rd_addr_b (mem_req.rd_back_addr),
        .rd_data_a (rd_front),
        .rd_data_b (rd_back)
    );

    // Read stage: zero both ends when empty, else forward the slot written in the same cycle
    always_comb
    begin
        if (s1_res_reg.empty)
        begin
            front_val = '0;
            back_val  = '0;
        end
        else
        begin
            front_val = s1_res_reg.byp_front ? s1_wdata_reg : rd_front;
            back_val  = s1_res_reg.byp_back  ? s1_wdata_reg : rd_back;
        end
        out_fields = {s1_res_reg.empty, s1_res_reg.full, s1_res_reg.occupancy,
                      back_val, front_val, s1_res_reg.status};
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg   <= res;
            s1_wdata_reg <= mem_req.wr_data;
        end
        if (s1_move && s1_valid_reg)
        begin
            m_tdata_reg <= cdeq_pkg::M_DATA_W'(out_fields);
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                m_tvalid_reg <= s1_valid_reg;
            end
            s1_valid_reg <= accept || (s1_valid_reg && !s1_move);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

FILE: sim/cdeq_checker.sv
// Scoreboard for the deque: mirrors ring state from accepted input beats,
// predicts each result beat and compares it against the output channel.
module cdeq_checker
    import cdeq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_DATA_W-1:0]   m_tdata,
    output int                         fail_count,
    output int                         outstanding
);

    // Result fields, lowest bits last so the cast matches m_tdata
    typedef struct packed {
        logic                   empty;
        logic                   full;
        logic [CNT_W-1:0]       occ;
        logic [ENTRY_WIDTH-1:0] back;
        logic [ENTRY_WIDTH-1:0] front;
        logic [STATUS_W-1:0]    status;
    } deque_view_t;

    // Mirror of the ring
    logic [ENTRY_WIDTH-1:0] slot_mirror [DEPTH];
    int                     front_ptr;
    int                     back_ptr;
    int                     stored;
    logic [CNT_W-1:0]       capacity_reg;
    deque_view_t            predicted_views [$];

    // Out-of-range capacity clamps to 1..DEPTH
    function automatic int ring_size(logic [CNT_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > DEPTH)
            return DEPTH;
        return int'(c);
    endfunction

    // An index past the capacity keeps climbing and wraps at DEPTH
    function automatic int ring_next(int idx, int cap);
        if (idx == cap - 1 || idx >= DEPTH - 1)
            return 0;
        return idx + 1;
    endfunction

    function automatic int ring_prev(int idx, int cap);
        if (idx == 0)
            return cap - 1;
        return idx - 1;
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        fail_count++;
    endtask

    // One operation on the mirror, returns the view after it
    task automatic apply_deque_op(input logic [OP_W-1:0] op,
                                  input logic [ENTRY_WIDTH-1:0] val,
                                  output deque_view_t view);
        int  cap;
        bit  was_full;
        bit  was_empty;
        cap       = ring_size(capacity_reg);
        was_full  = stored >= cap;
        was_empty = stored == 0;
        view      = '0;
        view.status = ST_DONE;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (was_full)
                begin
                    view.status = ST_FULL_ERR;
                end
                else
                begin
                    if (was_empty)
                    begin
                        front_ptr = 0;
                        back_ptr  = 0;
                    end
                    else if (op == OP_PUSH_BACK)
                        back_ptr = ring_next(back_ptr, cap);
                    else
                        front_ptr = ring_prev(front_ptr, cap);
                    slot_mirror[(op == OP_PUSH_BACK) ? back_ptr : front_ptr] = val;
                    stored++;
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (was_empty)
                begin
                    view.status = ST_EMPTY_ERR;
                end
                else
                begin
                    stored--;
                    if (stored == 0)
                    begin
                        front_ptr = 0;
                        back_ptr  = 0;
                    end
                    else if (op == OP_POP_BACK)
                        back_ptr = ring_prev(back_ptr, cap);
                    else
                        front_ptr = ring_next(front_ptr, cap);
                end
            end
            default:
                ; // status query, unknown codes too
        endcase
        front_ptr = front_ptr % DEPTH;
        back_ptr  = back_ptr % DEPTH;
        if (stored != 0)
        begin
            view.front = slot_mirror[front_ptr];
            view.back  = slot_mirror[back_ptr];
        end
        view.occ   = CNT_W'(stored);
        view.full  = stored >= cap;
        view.empty = stored == 0;
    endtask

    // Watch config, output and input channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        deque_view_t want;
        deque_view_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                slot_mirror[i] = '0;
            front_ptr    = 0;
            back_ptr     = 0;
            stored       = 0;
            capacity_reg = CNT_W'(DEPTH);
            predicted_views.delete();
            fail_count   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg = cfg_wdata;

            // result beat against oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = deque_view_t'(m_tdata[M_FIELDS_W-1:0]);
                if (predicted_views.size() == 0)
                begin
                    report_mismatch("unexpected result beat", 0, m_tdata);
                end
                else
                begin
                    want = predicted_views[0];
                    predicted_views.delete(0);
                    if (got.status !== want.status)
                        report_mismatch("status_code", want.status, got.status);
                    if (got.front !== want.front)
                        report_mismatch("front_value", want.front, got.front);
                    if (got.back !== want.back)
                        report_mismatch("back_value", want.back, got.back);
                    if (got.occ !== want.occ)
                        report_mismatch("occupancy", want.occ, got.occ);
                    if (got.full !== want.full)
                        report_mismatch("full_flag", want.full, got.full);
                    if (got.empty !== want.empty)
                        report_mismatch("empty_flag", want.empty, got.empty);
                end
            end

            // input beat: predict its result
            if (s_tvalid && s_tready)
            begin
                apply_deque_op(s_tdata[OP_W-1:0], s_tdata[OP_W +: ENTRY_WIDTH], want);
                predicted_views.insert(predicted_views.size(), want);
            end

            outstanding <= predicted_views.size();
        end
    end

endmodule

FILE: sim/circular_double_ended_queue_test.sv
// Stimulus and verdict for the deque; checking lives in cdeq_checker.
module circular_double_ended_queue_test;
    import cdeq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 140;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CNT_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int  fail_count;
    int  outstanding;
    int  cycle_count = 0;
    int  hold_req;
    bit  gaps_on;

    circular_double_ended_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    cdeq_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 4-unit clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin : result_drain
        int hold_served;
        int wait_cycles;
        hold_served = 0;
        m_tready    = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req != hold_served)
            begin
                hold_served = hold_req;
                m_tready   <= 1'b0;
                wait_cycles = HOLD_CYCLES;
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                m_tready   <= 1'b0;
                wait_cycles = $urandom_range(1, 5);
            end
            else
            begin
                m_tready   <= 1'b1;
                wait_cycles = 1;
            end
            repeat (wait_cycles) @(posedge clk);
        end
    end

    // One input beat, with an optional idle burst ahead of it
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [ENTRY_WIDTH-1:0] val);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - OP_W - ENTRY_WIDTH){1'b0}}, val, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Op mix per mode: 0 mostly pushes, 1 mostly pops, 2 even
    function automatic logic [OP_W-1:0] pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 94)
            return OP_W'($urandom_range(5, 7));
        if (r >= 88)
            return OP_STATUS;
        case (mode)
            0:       return (r < 35) ? OP_PUSH_BACK : (r < 70) ? OP_PUSH_FRONT :
                            (r < 79) ? OP_POP_BACK  : OP_POP_FRONT;
            1:       return (r < 9)  ? OP_PUSH_BACK : (r < 18) ? OP_PUSH_FRONT :
                            (r < 53) ? OP_POP_BACK  : OP_POP_FRONT;
            default: return (r < 22) ? OP_PUSH_BACK : (r < 44) ? OP_PUSH_FRONT :
                            (r < 66) ? OP_POP_BACK  : OP_POP_FRONT;
        endcase
    endfunction

    function automatic logic [ENTRY_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return ENTRY_WIDTH'($urandom());
    endfunction

    // Main stimulus
    initial
    begin : stimulus
        int cap_table [7];
        int cap;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        hold_req    = 0;
        gaps_on     = 1'b1;
        cap_table   = '{1, 2, 64, 0, 127, 65, 3};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty errors, value extremes, both ends, unknown ops
        send_beat(OP_STATUS,     16'h0000);
        send_beat(OP_POP_BACK,   16'h0000);
        send_beat(OP_POP_FRONT,  16'hFFFF);
        send_beat(OP_PUSH_BACK,  16'hFFFF);
        send_beat(OP_PUSH_FRONT, 16'h0000);
        send_beat(OP_PUSH_BACK,  16'h8001);
        send_beat(OP_STATUS,     16'h1234);
        send_beat(OP_W'(5),      16'hFFFF);
        send_beat(OP_W'(6),      16'hFFFF);
        send_beat(OP_W'(7),      16'hFFFF);
        send_beat(OP_POP_FRONT,  16'h0000);
        send_beat(OP_POP_BACK,   16'h0000);
        send_beat(OP_POP_BACK,   16'h0000);
        send_beat(OP_POP_BACK,   16'h0000);
        send_beat(OP_PUSH_FRONT, 16'hAAAA);
        send_beat(OP_PUSH_FRONT, 16'h5555);
        send_beat(OP_POP_FRONT,  16'h0000);
        send_beat(OP_POP_FRONT,  16'h0000);
        send_beat(OP_PUSH_BACK,  16'h1234);
        send_beat(OP_POP_FRONT,  16'h0000);
        wait_drained();

        // Fill every slot at full capacity, overflow, then drain and underflow.
        // Leaves no unwritten slot behind for the capacity changes that follow.
        for (int i = 0; i < DEPTH; i++)
            send_beat(OP_PUSH_BACK, pick_value());
        send_beat(OP_PUSH_BACK,  16'hFFFF);
        send_beat(OP_PUSH_FRONT, 16'hFFFF);
        send_beat(OP_STATUS,     16'h0000);
        for (int i = 0; i < DEPTH; i++)
            send_beat(OP_POP_FRONT, pick_value());
        send_beat(OP_POP_FRONT, 16'h0000);
        wait_drained();

        // Random phases; contents carry over when the capacity changes
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            cap = (p < 7) ? cap_table[p] : $urandom_range(0, 127);
            gaps_on <= (p % 4 != 3) && (p < PHASE_COUNT - 2);
            write_capacity(cap);
            if (p == 2)
                hold_req <= hold_req + 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 5 && i == PHASE_ITEMS / 2)
                    wait_drained();
                send_beat(pick_op(p % 3), pick_value());
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
src/cdeq_pkg.sv
src/cdeq_ram.sv
src/cdeq_ctrl.sv
src/circular_double_ended_queue.sv
sim/cdeq_checker.sv
sim/circular_double_ended_queue_test.sv
